>>> design/assert_macros.svh
// Assertion macros for the waterfall row renderer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off in reset
`define WRPC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off in reset
`define WRPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> design/wrpc_pkg.sv
// Package: shared types, codes and defaults of the waterfall row renderer
`timescale 1ns / 1ps
package wrpc_pkg;

	localparam int DEF_MAX_BINS      = 4096;
	localparam int DEF_MAX_WIDTH     = 4096;
	localparam int DEF_PALETTE_DEPTH = 16;

	localparam logic [1:0] OP_BIN    = 2'd0;
	localparam logic [1:0] OP_PAL    = 2'd1;
	localparam logic [1:0] OP_RENDER = 2'd2;

	localparam logic [2:0] REG_MIN_DB     = 3'd0;
	localparam logic [2:0] REG_MAX_DB     = 3'd1;
	localparam logic [2:0] REG_FULL_START = 3'd2;
	localparam logic [2:0] REG_VIEW_START = 3'd3;
	localparam logic [2:0] REG_VIEW_STOP  = 3'd4;
	localparam logic [2:0] REG_RATE       = 3'd5;
	localparam logic [2:0] REG_WIDTH      = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_MUL_S, S_DIV_S, S_MUL_E, S_DIV_E, S_RANGE,
		S_MUL_B, S_DIV_B, S_MUL_STOP, S_DIV_STOP, S_BOUND, S_SCAN,
		S_MUL_SC, S_DIV_SC, S_PAL
	} state_t;

	function automatic logic [23:0] default_color(input logic [8:0] i);
		logic [23:0] c;
		case (i)
			9'd1: c = 24'h000080;
			9'd2: c = 24'h0080FF;
			9'd3: c = 24'h00FF80;
			9'd4: c = 24'hFFFF00;
			9'd5: c = 24'hFF0000;
			default: c = 24'h000000;
		endcase
		return c;
	endfunction

endpackage

>>> design/wrpc_ram.sv
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
module wrpc_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> design/waterfall_row_peak_colormap.sv
// Top level: waterfall row renderer with peak decimation and palette lookup
`timescale 1ns / 1ps
// Bin and palette writes never raise busy. A render request that yields a color
// holds busy while one shared shift-subtract divider (one quotient bit a cycle,
// DQ_W bits, DQ_W = max(bin address bits + 1, 8), 13 at default) runs: two
// divisions for the column bounds, one for the color scale (skipped when max_db
// is not above min_db), plus a scan that reads the bins through the bin memory
// port, and setup states. After a register write or a new frame length, two more
// divisions recompute the view range once, at the next render, unless the frame
// holds one bin. The strobe result_valid marks each result for one cycle; it
// cannot be stalled.
module waterfall_row_peak_colormap #(
	parameter int MAX_BINS      = wrpc_pkg::DEF_MAX_BINS,
	parameter int MAX_WIDTH     = wrpc_pkg::DEF_MAX_WIDTH,
	parameter int PALETTE_DEPTH = wrpc_pkg::DEF_PALETTE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [11:0]        index,
	input  logic signed [23:0] bin_value,
	input  logic               bin_invalid,
	input  logic [23:0]        entry_color,
	input  logic               last,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [39:0]        cfg_data,
	output logic               result_valid,
	output logic [11:0]        column,
	output logic [3:0]         color_index,
	output logic [23:0]        pixel_color
);
	import wrpc_pkg::*;

	localparam int BIN_AW = $clog2(MAX_BINS);
	localparam int CNT_W  = $clog2(MAX_BINS + 1);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int DQ_W   = (BIN_AW + 1 >= 8) ? BIN_AW + 1 : 8;
	localparam int CW     = $clog2(DQ_W);
	localparam int RW     = 41 + DQ_W;
	localparam int PLW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int PL_RST = (PALETTE_DEPTH > 5) ? 5 : PALETTE_DEPTH - 1;

	state_t state_q, state_d;

	logic signed [23:0] min_db_q, max_db_q;
	logic [39:0] full_q, vstart_q, vstop_q, rate_q;
	logic [12:0] width_q;

	logic [CNT_W-1:0]  bin_count_q;
	logic              range_ok_q;
	logic [BIN_AW-1:0] start_q, end_q;
	logic [39:0]       soff_q, toff_q, span_q;
	logic [11:0]       x_q;
	logic [WW-1:0]     w_q;
	logic [BIN_AW:0]   begin_q, stop_q, cur_q;
	logic              vld_s1, first_s1;
	logic signed [23:0] peak_q;

	logic [RW-1:0]   rem_q, dsh_q;
	logic [DQ_W-1:0] quo_q;
	logic [CW-1:0]   cnt_q;

	logic [23:0]    pal_q [PALETTE_DEPTH];
	logic [PLW-1:0] plast_q;

	logic               acc, render_ok, bin_we, pal_we;
	logic [WW-1:0]      w_c;
	logic [BIN_AW-1:0]  n1;
	logic [39:0]        span_c, soff_c, toff_c;
	logic signed [40:0] sdiff, tdiff;
	logic [BIN_AW:0]    vis, quo_b, s_raw, s_c, beg_c;
	logic [DQ_W-1:0]    e_c;
	logic [39:0]        mul_a, dvs;
	logic [DQ_W-1:0]    mul_b;
	logic [RW-1:0]      add_c, prod;
	logic               ge, issue, scale_ok;
	logic signed [23:0] clamp_c;
	logic [24:0]        cdiff;
	logic [PLW-1:0]     cidx;
	logic [24:0]        rd_data;
	logic               rd_inv;
	logic signed [23:0] rd_val;

	assign busy   = (state_q != S_IDLE);
	assign acc    = start && !busy;
	assign bin_we = acc && op == OP_BIN && 32'(index) < MAX_BINS;
	assign pal_we = acc && op == OP_PAL && 32'(index) < PALETTE_DEPTH;

	always_comb begin
		if (width_q == 13'd0) begin
			w_c = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(width_q);
		end
	end

	assign render_ok = acc && op == OP_RENDER && bin_count_q != '0 && 32'(index) < 32'(w_c);
	assign n1        = BIN_AW'(bin_count_q - CNT_W'(1));
	assign span_c    = (rate_q == 40'd0) ? 40'd1 : rate_q;
	assign sdiff     = signed'({1'b0, vstart_q}) - signed'({1'b0, full_q});
	assign tdiff     = signed'({1'b0, vstop_q}) - signed'({1'b0, full_q});

	always_comb begin
		if (sdiff < 0) begin
			soff_c = 40'd0;
		end else if (sdiff > signed'({1'b0, span_c})) begin
			soff_c = span_c;
		end else begin
			soff_c = sdiff[39:0];
		end
		if (tdiff > signed'({1'b0, span_c})) begin
			toff_c = span_c;
		end else if (tdiff < signed'({1'b0, soff_c})) begin
			toff_c = soff_c;
		end else begin
			toff_c = tdiff[39:0];
		end
	end

	assign vis      = {1'b0, end_q} - {1'b0, start_q} + (BIN_AW + 1)'(1);
	assign scale_ok = max_db_q > min_db_q;

	always_comb begin
		if (peak_q > max_db_q) begin
			clamp_c = max_db_q;
		end else if (peak_q < min_db_q) begin
			clamp_c = min_db_q;
		end else begin
			clamp_c = peak_q;
		end
	end
	assign cdiff = 25'({clamp_c[23], clamp_c} - {min_db_q[23], min_db_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		add_c = '0;
		dvs   = '0;
		case (state_q)
			S_MUL_S: begin
				mul_a = soff_q;
				mul_b = DQ_W'(n1);
				dvs   = span_q;
			end
			S_MUL_E: begin
				mul_a = toff_q;
				mul_b = DQ_W'(n1);
				add_c = RW'(span_q - 40'd1);
				dvs   = span_q;
			end
			S_MUL_B: begin
				mul_a = 40'(x_q);
				mul_b = DQ_W'(vis);
				dvs   = 40'(w_q);
			end
			S_MUL_STOP: begin
				mul_a = 40'(x_q) + 40'd1;
				mul_b = DQ_W'(vis);
				dvs   = 40'(w_q);
			end
			S_MUL_SC: begin
				mul_a = 40'(cdiff);
				mul_b = DQ_W'(plast_q);
				dvs   = 40'(25'({max_db_q[23], max_db_q} - {min_db_q[23], min_db_q}));
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign prod = RW'(mul_a * mul_b) + add_c;
	assign ge   = rem_q >= dsh_q;

	assign quo_b = (BIN_AW + 1)'(quo_q);
	assign s_raw = {1'b0, start_q} + quo_b;
	assign e_c   = (quo_q > DQ_W'(n1)) ? DQ_W'(n1) :
		(quo_q < DQ_W'(start_q)) ? DQ_W'(start_q) : quo_q;

	always_comb begin
		s_c = s_raw;
		if (s_c < begin_q + (BIN_AW + 1)'(1)) begin
			s_c = begin_q + (BIN_AW + 1)'(1);
		end
		if (s_c > {1'b0, end_q} + (BIN_AW + 1)'(1)) begin
			s_c = {1'b0, end_q} + (BIN_AW + 1)'(1);
		end
		beg_c = (begin_q > {1'b0, end_q}) ? {1'b0, end_q} : begin_q;
	end

	assign issue  = cur_q < stop_q;
	assign rd_inv = rd_data[24];
	assign rd_val = signed'(rd_data[23:0]);
	assign cidx   = !scale_ok ? '0 :
		(quo_q > DQ_W'(plast_q)) ? plast_q : PLW'(quo_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (render_ok) begin
					state_d = (range_ok_q || bin_count_q == CNT_W'(1)) ? S_MUL_B : S_PREP;
				end
			end
			S_PREP:     state_d = S_MUL_S;
			S_MUL_S:    state_d = S_DIV_S;
			S_DIV_S:    state_d = (cnt_q == '0) ? S_MUL_E : S_DIV_S;
			S_MUL_E:    state_d = S_DIV_E;
			S_DIV_E:    state_d = (cnt_q == '0) ? S_RANGE : S_DIV_E;
			S_RANGE:    state_d = S_MUL_B;
			S_MUL_B:    state_d = S_DIV_B;
			S_DIV_B:    state_d = (cnt_q == '0) ? S_MUL_STOP : S_DIV_B;
			S_MUL_STOP: state_d = S_DIV_STOP;
			S_DIV_STOP: state_d = (cnt_q == '0) ? S_BOUND : S_DIV_STOP;
			S_BOUND:    state_d = S_SCAN;
			S_SCAN: begin
				if (!issue && !vld_s1) begin
					state_d = scale_ok ? S_MUL_SC : S_PAL;
				end
			end
			S_MUL_SC:   state_d = S_DIV_SC;
			S_DIV_SC:   state_d = (cnt_q == '0) ? S_PAL : S_DIV_SC;
			S_PAL:      state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	wrpc_ram #(
		.WIDTH (25),
		.DEPTH (MAX_BINS)
	) u_bins (
		.clk   (clk),
		.we    (bin_we),
		.waddr (BIN_AW'(index)),
		.wdata ({bin_invalid, bin_value}),
		.raddr (cur_q[BIN_AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			min_db_q     <= -24'sd30720;
			max_db_q     <= 24'sd0;
			full_q       <= 40'd0;
			vstart_q     <= 40'd0;
			vstop_q      <= 40'd1000000;
			rate_q       <= 40'd1000000;
			width_q      <= 13'd1024;
			bin_count_q  <= '0;
			range_ok_q   <= 1'b0;
			plast_q      <= PLW'(PL_RST);
			vld_s1       <= 1'b0;
			result_valid <= 1'b0;
			for (int i = 0; i < PALETTE_DEPTH; i++) begin
				pal_q[i] <= default_color(9'(i));
			end
		end else begin
			state_q      <= state_d;
			result_valid <= 1'b0;
			if (cfg_we) begin
				range_ok_q <= 1'b0;
				case (cfg_index)
					REG_MIN_DB:     min_db_q <= signed'(cfg_data[23:0]);
					REG_MAX_DB:     max_db_q <= signed'(cfg_data[23:0]);
					REG_FULL_START: full_q   <= cfg_data;
					REG_VIEW_START: vstart_q <= cfg_data;
					REG_VIEW_STOP:  vstop_q  <= cfg_data;
					REG_RATE:       rate_q   <= cfg_data;
					REG_WIDTH:      width_q  <= cfg_data[12:0];
					default:        range_ok_q <= range_ok_q;
				endcase
			end
			if (bin_we && last) begin
				bin_count_q <= CNT_W'(index) + CNT_W'(1);
				range_ok_q  <= 1'b0;
			end
			if (pal_we) begin
				pal_q[PLW'(index)] <= entry_color;
				if (last) begin
					plast_q <= PLW'(index);
				end
			end
			case (state_q)
				S_IDLE: begin
					if (render_ok && !range_ok_q && bin_count_q == CNT_W'(1)) begin
						start_q    <= '0;
						end_q      <= '0;
						range_ok_q <= 1'b1;
					end
				end
				S_MUL_E: begin
					start_q <= quo_q[BIN_AW-1:0];
				end
				S_RANGE: begin
					end_q      <= BIN_AW'(e_c);
					range_ok_q <= 1'b1;
				end
				S_SCAN: begin
					vld_s1 <= issue;
				end
				S_PAL: begin
					result_valid <= 1'b1;
				end
				default: begin
					vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q <= index;
				w_q <= w_c;
			end
			S_PREP: begin
				soff_q <= soff_c;
				toff_q <= toff_c;
				span_q <= span_c;
			end
			S_MUL_S, S_MUL_E, S_MUL_B, S_MUL_STOP, S_MUL_SC: begin
				rem_q <= prod;
				dsh_q <= RW'(dvs) << (DQ_W - 1);
				quo_q <= '0;
				cnt_q <= CW'(DQ_W - 1);
			end
			S_DIV_S, S_DIV_E, S_DIV_B, S_DIV_STOP, S_DIV_SC: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= {quo_q[DQ_W-2:0], ge};
				cnt_q <= cnt_q - CW'(1);
			end
			S_BOUND: begin
				stop_q  <= s_c;
				begin_q <= beg_c;
				cur_q   <= beg_c;
			end
			S_SCAN: begin
				first_s1 <= cur_q == begin_q;
				if (issue) begin
					cur_q <= cur_q + (BIN_AW + 1)'(1);
				end
				if (vld_s1) begin
					if (first_s1) begin
						peak_q <= rd_inv ? min_db_q : rd_val;
					end else if (!rd_inv && rd_val > peak_q) begin
						peak_q <= rd_val;
					end
				end
			end
			S_PAL: begin
				column      <= x_q;
				color_index <= 4'(cidx);
				pixel_color <= (32'(cidx) < PALETTE_DEPTH) ? pal_q[cidx] : pal_q[0];
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
		if (state_q == S_MUL_STOP) begin
			begin_q <= s_raw;
		end
	end

endmodule

>>> design/wrpc_chk.sv
// Port-level checker for the waterfall row renderer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wrpc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] op,
	input logic       result_valid
);
	import wrpc_pkg::*;

	`WRPC_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid)
	`WRPC_ASSERT_NOW(a_result_after_busy, result_valid, $past(busy))
	`WRPC_ASSERT_NEXT(a_write_no_busy, start && !busy && op != OP_RENDER, !busy)
	`WRPC_ASSERT_NOW(a_busy_from_render, $rose(busy), $past(start) && $past(op) == OP_RENDER)

endmodule

bind waterfall_row_peak_colormap wrpc_chk u_wrpc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.op           (op),
	.result_valid (result_valid)
);

>>> tb/tb_waterfall_row_peak_colormap.sv
// Testbench for waterfall_row_peak_colormap: queued random and directed requests
`timescale 1ns / 1ps
module tb_waterfall_row_peak_colormap;
	import wrpc_pkg::*;

	localparam logic [1:0] K_REQ = 2'd0;
	localparam logic [1:0] K_CFG = 2'd1;
	localparam logic [1:0] K_DRAIN = 2'd2;
	localparam int SETTLE = 60;

	typedef struct {
		logic [1:0] kind;
		logic [1:0] op;
		logic [11:0] idx;
		logic [23:0] val;
		logic inv;
		logic [23:0] color;
		logic lst;
		logic [2:0] reg_i;
		logic [39:0] data;
	} request_t;

	typedef struct {
		logic [11:0] col;
		logic [3:0] cidx;
		logic [23:0] color;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] op = OP_BIN;
	logic [11:0] index = '0;
	logic signed [23:0] bin_value = '0;
	logic bin_invalid = 1'b0;
	logic [23:0] entry_color = '0;
	logic last = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_MIN_DB;
	logic [39:0] cfg_data = '0;
	logic busy, result_valid;
	logic [11:0] column;
	logic [3:0] color_index;
	logic [23:0] pixel_color;

	waterfall_row_peak_colormap uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .index(index),
		.bin_value(bin_value), .bin_invalid(bin_invalid), .entry_color(entry_color),
		.last(last), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .column(column), .color_index(color_index),
		.pixel_color(pixel_color)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	request_t pending[$];
	pixel_t expected_pixels[$];
	request_t cur;
	int errors = 0;
	int accepted = 0;
	int hold_cnt = 0;

	// shadow of the block
	int sh_min = -30720, sh_max = 0;
	longint sh_fstart = 0, sh_vstart = 0, sh_vstop = 1000000, sh_rate = 1000000;
	int sh_width = 1024;
	logic [24:0] sh_bins [4096];
	int sh_count = 0;
	logic [23:0] sh_pal [16];
	int sh_pal_last = 5;

	// generator view of the frame
	bit gen_written [4096];
	int gen_count = 0, gen_min = -30720, gen_max = 0, gen_width = 1024;

	initial begin
		for (int i = 0; i < 16; i++)
			sh_pal[i] = 24'h0;
		sh_pal[1] = 24'h000080;
		sh_pal[2] = 24'h0080FF;
		sh_pal[3] = 24'h00FF80;
		sh_pal[4] = 24'hFFFF00;
		sh_pal[5] = 24'hFF0000;
	end

	task automatic render_column(input int x);
		longint w, span, soff, toff, n1, st, en, vis, bg, sp, c;
		int pk, v, cidx;
		pixel_t px;
		if (sh_count == 0) return;
		w = (sh_width == 0) ? 1 : ((sh_width > 4096) ? 4096 : sh_width);
		if (x >= w) return;
		st = 0;
		en = 0;
		if (sh_count > 1) begin
			span = (sh_rate == 0) ? 1 : sh_rate;
			soff = sh_vstart - sh_fstart;
			if (soff < 0) soff = 0;
			if (soff > span) soff = span;
			toff = sh_vstop - sh_fstart;
			if (toff > span) toff = span;
			if (toff < soff) toff = soff;
			n1 = sh_count - 1;
			st = (soff * n1) / span;
			en = (toff * n1 + span - 1) / span;
			if (en > n1) en = n1;
			if (en < st) en = st;
		end
		vis = en - st + 1;
		bg = st + (x * vis) / w;
		sp = st + ((x + 1) * vis) / w;
		if (sp < bg + 1) sp = bg + 1;
		if (sp > en + 1) sp = en + 1;
		if (bg > en) bg = en;
		pk = sh_bins[bg][24] ? sh_min : int'($signed(sh_bins[bg][23:0]));
		for (longint i = bg + 1; i < sp; i++) begin
			v = int'($signed(sh_bins[i][23:0]));
			if (!sh_bins[i][24] && v > pk) pk = v;
		end
		cidx = 0;
		if (sh_max > sh_min) begin
			c = pk;
			if (c > sh_max) c = sh_max;
			if (c < sh_min) c = sh_min;
			cidx = int'(((c - sh_min) * sh_pal_last) / (longint'(sh_max) - sh_min));
			if (cidx > sh_pal_last) cidx = sh_pal_last;
		end
		px.col = x[11:0];
		px.cidx = cidx[3:0];
		px.color = sh_pal[cidx];
		expected_pixels.push_back(px);
	endtask

	task automatic apply_request(input request_t r);
		case (r.op)
			OP_BIN: begin
				sh_bins[r.idx] = {r.inv, r.val};
				if (r.lst) sh_count = int'(r.idx) + 1;
			end
			OP_PAL: if (r.idx < 16) begin
				sh_pal[r.idx] = r.color;
				if (r.lst) sh_pal_last = int'(r.idx);
			end
			OP_RENDER: render_column(int'(r.idx));
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [2:0] i, input logic [39:0] d);
		case (i)
			REG_MIN_DB: sh_min = int'($signed(d[23:0]));
			REG_MAX_DB: sh_max = int'($signed(d[23:0]));
			REG_FULL_START: sh_fstart = longint'(d);
			REG_VIEW_START: sh_vstart = longint'(d);
			REG_VIEW_STOP: sh_vstop = longint'(d);
			REG_RATE: sh_rate = longint'(d);
			REG_WIDTH: sh_width = int'(d[12:0]);
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic go, we;
		int idle_pct;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
		end else begin
			go = start;
			we = 1'b0;
			idle_pct = (accepted < 217) ? 35 : ((accepted < 434) ? 55 : 0);
			if (start && !busy) begin
				apply_request(cur);
				accepted++;
				go = 1'b0;
			end
			if (!go) begin
				if (hold_cnt > 0) begin
					hold_cnt--;
				end else if (pending.size() > 0) begin
					case (pending[0].kind)
						K_REQ: if ($urandom_range(99) >= idle_pct) begin
							cur = pending.pop_front();
							op <= cur.op;
							index <= cur.idx;
							bin_value <= cur.val;
							bin_invalid <= cur.inv;
							entry_color <= cur.color;
							last <= cur.lst;
							go = 1'b1;
						end
						K_CFG: begin
							cur = pending.pop_front();
							cfg_index <= cur.reg_i;
							cfg_data <= cur.data;
							apply_config(cur.reg_i, cur.data);
							we = 1'b1;
						end
						default: if (expected_pixels.size() == 0 && !busy) begin
							void'(pending.pop_front());
							hold_cnt = SETTLE;
						end
					endcase
				end
			end
			start <= go;
			cfg_we <= we;
		end
	end

	always @(posedge clk) begin
		pixel_t px;
		if (arst_n && result_valid) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected pixel col=%0d idx=%0d color=%06h", $time,
					column, color_index, pixel_color);
				errors++;
			end else begin
				px = expected_pixels.pop_front();
				if (column !== px.col) begin
					$display("%0t: column expected %0d actual %0d", $time, px.col, column);
					errors++;
				end
				if (color_index !== px.cidx) begin
					$display("%0t: color_index expected %0d actual %0d", $time, px.cidx,
						color_index);
					errors++;
				end
				if (pixel_color !== px.color) begin
					$display("%0t: pixel_color expected %06h actual %06h", $time, px.color,
						pixel_color);
					errors++;
				end
			end
		end
	end

	task automatic push_req(input logic [1:0] o, input int i, input int v, input bit inv,
			input logic [23:0] c, input bit l);
		request_t r;
		bit ok;
		r.kind = K_REQ;
		r.op = o;
		r.idx = i[11:0];
		r.val = v[23:0];
		r.inv = inv;
		r.color = c;
		r.lst = l;
		r.reg_i = REG_MIN_DB;
		r.data = '0;
		if (o == OP_BIN) begin
			gen_written[i] = 1'b1;
			if (l) begin
				ok = 1'b1;
				for (int k = 0; k < i; k++)
					if (!gen_written[k]) ok = 1'b0;
				if (ok) gen_count = i + 1;
				else r.lst = 1'b0;
			end
		end
		pending.push_back(r);
	endtask

	task automatic push_cfg(input logic [2:0] i, input logic [39:0] d);
		request_t r;
		r.kind = K_CFG;
		r.op = OP_BIN;
		r.idx = '0;
		r.val = '0;
		r.inv = 1'b0;
		r.color = '0;
		r.lst = 1'b0;
		r.reg_i = i;
		r.data = d;
		if (i == REG_MIN_DB) gen_min = int'($signed(d[23:0]));
		if (i == REG_MAX_DB) gen_max = int'($signed(d[23:0]));
		if (i == REG_WIDTH) gen_width = (d[12:0] == 0) ? 1 :
			((d[12:0] > 4096) ? 4096 : int'(d[12:0]));
		pending.push_back(r);
	endtask

	task automatic push_drain();
		request_t r;
		r.kind = K_DRAIN;
		r.op = OP_BIN;
		r.idx = '0;
		r.val = '0;
		r.inv = 1'b0;
		r.color = '0;
		r.lst = 1'b0;
		r.reg_i = REG_MIN_DB;
		r.data = '0;
		pending.push_back(r);
	endtask

	function automatic int level_in_scale();
		if (gen_max > gen_min && $urandom_range(9) < 7)
			return gen_min + int'($urandom_range(gen_max - gen_min));
		return int'($urandom);
	endfunction

	function automatic logic [39:0] rand40();
		return 40'({$urandom, $urandom});
	endfunction

	initial begin
		int n, sel, lo, hi;
		logic [39:0] fs, vs, vt, rt;
		// empty frame, unknown op, palette index out of range
		push_req(OP_RENDER, 0, 0, 0, 0, 0);
		push_req(2'd3, 4095, -1, 1, 24'hFFFFFF, 1);
		push_req(OP_PAL, 20, 0, 0, 24'h123456, 1);
		push_req(OP_BIN, 0, 8388607, 0, 0, 0);
		push_req(OP_BIN, 1, -8388608, 1, 0, 0);
		push_req(OP_BIN, 2, -8388608, 0, 0, 0);
		push_req(OP_BIN, 3, -15000, 0, 0, 1);
		push_req(OP_RENDER, 0, 0, 0, 0, 0);
		push_req(OP_RENDER, 1023, 0, 0, 0, 0);
		push_req(OP_RENDER, 1024, 0, 0, 0, 0);
		push_req(OP_RENDER, 4095, 0, 0, 0, 0);
		push_req(OP_PAL, 15, 0, 0, 24'hFFFFFF, 1);
		push_req(OP_PAL, 0, 0, 0, 24'hA5A5A5, 0);
		push_req(OP_RENDER, 600, 0, 0, 0, 0);
		push_req(OP_BIN, 0, -2000, 1, 0, 1);
		push_req(OP_RENDER, 5, 0, 0, 0, 0);
		push_drain();
		push_req(OP_BIN, 0, 0, 0, 0, 1);
		push_req(OP_RENDER, 0, 0, 0, 0, 0);
		for (int ph = 0; ph < 10; ph++) begin
			push_drain();
			sel = ph % 5;
			lo = (sel == 0) ? -8388608 : -int'($urandom_range(40000));
			hi = (sel == 0) ? 8388607 : ((sel == 1) ? lo - int'($urandom_range(100)) :
				int'($urandom_range(20000)) - 5000);
			if (ph == 9) begin
				lo = 0;
				hi = 0;
			end
			push_cfg(REG_MIN_DB, 40'(lo));
			push_cfg(REG_MAX_DB, 40'(hi));
			rt = (sel == 0) ? 40'hFF_FFFF_FFFF : ((sel == 1) ? 40'd1 :
				40'($urandom_range(5000000, 1)));
			fs = (sel == 2) ? rand40() : 40'($urandom_range(1000000));
			vs = (sel == 3) ? fs - 40'($urandom_range(1000)) : fs + 40'($urandom_range(rt));
			vt = (sel == 4) ? vs - 40'($urandom_range(1000)) :
				vs + 40'($urandom_range(rt) + 1);
			if (sel == 0) begin
				fs = 40'h0;
				vs = 40'h0;
				vt = 40'hFF_FFFF_FFFF;
			end
			push_cfg(REG_FULL_START, fs);
			push_cfg(REG_VIEW_START, vs);
			push_cfg(REG_VIEW_STOP, vt);
			push_cfg(REG_RATE, rt);
			case (ph % 6)
				0: push_cfg(REG_WIDTH, 40'd4096);
				1: push_cfg(REG_WIDTH, 40'd0);
				2: push_cfg(REG_WIDTH, 40'd8191);
				3: push_cfg(REG_WIDTH, 40'd1);
				default: push_cfg(REG_WIDTH, 40'($urandom_range(64, 2)));
			endcase
			if (ph == 4) push_cfg(REG_WIDTH, 40'h1FFF);
			n = 0;
			while (n < 40) begin
				sel = $urandom_range(99);
				if (sel < 22 || gen_count == 0) begin
					lo = $urandom_range(40, 1);
					if (ph == 7 && n == 0) lo = 200;
					for (int k = 0; k < lo; k++)
						push_req(OP_BIN, k, level_in_scale(), $urandom_range(4) == 0,
							24'($urandom), k == lo - 1);
					n += lo;
				end else if (sel < 75) begin
					push_req(OP_RENDER, ($urandom_range(9) == 0) ? int'($urandom_range(4095)) :
						int'($urandom_range(gen_width - 1)), int'($urandom),
						$urandom_range(1), 24'($urandom), $urandom_range(1));
					n++;
				end else if (sel < 85) begin
					push_req(OP_PAL, ($urandom_range(4) == 0) ? int'($urandom_range(4095)) :
						int'($urandom_range(15)), int'($urandom), $urandom_range(1),
						24'($urandom), $urandom_range(3) == 0);
					n++;
				end else if (sel < 88) begin
					push_req(2'd3, $urandom_range(4095), int'($urandom), $urandom_range(1),
						24'($urandom), $urandom_range(1));
					n++;
				end else begin
					push_req(OP_BIN, $urandom_range(4095), int'($urandom), $urandom_range(1),
						24'($urandom), $urandom_range(1));
					n++;
				end
				if (n > 20 && n < 24) push_drain();
			end
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() > 0 || start) @(posedge clk);
		while (expected_pixels.size() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0 && expected_pixels.size() == 0)
			$display("tb_waterfall_row_peak_colormap passed");
		else
			$display("tb_waterfall_row_peak_colormap failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb_waterfall_row_peak_colormap failed");
		$finish;
	end

endmodule
